// ----- rtl/sorted_table_binary_search_top_assert.svh -----
// Assertion macros for the sorted table search block.
// Used by sorted_table_binary_search_top; needs clock and reset in scope.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define STBS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define STBS_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define STBS_ASSERT(label, prop, msg)
`define STBS_ASSERT_RST(label, prop, msg)
`endif
`endif

// ----- rtl/stbs_pkg.sv -----
// Shared types and constants for the sorted table search block.
// No dependencies.
`timescale 1ns / 1ps
package stbs_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = 4;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   // bounds hold 0..TABLE_DEPTH and any window field value
   localparam int BOUND_W     = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [IDX_W-1:0]              index_type;
   typedef logic [BOUND_W-1:0]            bound_type;

   typedef struct packed {
      logic      kind;
      index_type entry_index;
      value_type entry_value;
      value_type search_key;
      index_type window_low;
      index_type window_high;
   } req_type;

   typedef struct packed {
      logic      found;
      index_type found_index;
   } rsp_type;

   typedef struct packed {
      logic write_entry;
      logic start;
      logic step;
      logic capture;
   } ctrl_cmd_type;

   typedef struct packed {
      logic done;
   } dp_status_type;

endpackage

// ----- rtl/stbs_chan_if.sv -----
// Valid/ready channel interfaces for request and response traffic.
// Depends on stbs_pkg.
`timescale 1ns / 1ps
interface stbs_req_if;
   import stbs_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface stbs_rsp_if;
   import stbs_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/stbs_ctrl.sv -----
// Controller for the sorted table search: request intake, probe loop,
// response valid. Depends on stbs_pkg.
`timescale 1ns / 1ps
module stbs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_kind,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   input  stbs_pkg::dp_status_type status,
   output stbs_pkg::ctrl_cmd_type  cmd
);
   import stbs_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_PROBE = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in         = state_ff;
      cmd.write_entry  = 1'b0;
      cmd.start        = 1'b0;
      cmd.step         = 1'b0;
      cmd.capture      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_SEARCH) begin
                  cmd.start = 1'b1;
                  state_in  = ST_PROBE;
               end else begin
                  cmd.write_entry = 1'b1;
               end
            end
         end
         ST_PROBE: begin
            if (!status.done) begin
               cmd.step = 1'b1;
            end else if (slot_free) begin
               // result waits here until the output register is free
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.capture) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/stbs_dp.sv -----
// Datapath for the sorted table search: table registers, search bounds,
// midpoint probe and compare, response register. Depends on stbs_pkg.
`timescale 1ns / 1ps
module stbs_dp (
   input  logic                    clock,
   input  stbs_pkg::req_type       req_data,
   input  stbs_pkg::ctrl_cmd_type  cmd,
   output stbs_pkg::dp_status_type status,
   output stbs_pkg::rsp_type       rsp_data
);
   import stbs_pkg::*;

   value_type table_ff [TABLE_DEPTH];
   value_type key_ff;
   bound_type low_ff, low_in;
   bound_type high_p1_ff, high_p1_in;   // high bound plus one
   rsp_type   rsp_ff, rsp_in;

   logic [BOUND_W:0] mid_sum;
   bound_type        mid;
   bound_type        win_high_p1;
   value_type        probe;
   logic             in_window;
   logic             hit;

   assign in_window = (low_ff < high_p1_ff);
   // in_window guarantees low + high_p1 - 1 does not underflow
   assign mid_sum   = {1'b0, low_ff} + {1'b0, high_p1_ff} - (BOUND_W + 1)'(1);
   assign mid       = mid_sum[BOUND_W:1];
   assign probe     = table_ff[mid[ADDR_W-1:0]];
   assign hit       = in_window & (key_ff == probe);
   assign status.done = ~in_window | hit;

   always_comb begin
      win_high_p1 = BOUND_W'(req_data.window_high) + BOUND_W'(1);
      if (win_high_p1 > BOUND_W'(TABLE_DEPTH)) begin
         win_high_p1 = BOUND_W'(TABLE_DEPTH);
      end
   end

   always_comb begin
      low_in     = low_ff;
      high_p1_in = high_p1_ff;
      if (cmd.start) begin
         low_in     = BOUND_W'(req_data.window_low);
         high_p1_in = win_high_p1;
      end else if (cmd.step) begin
         if (key_ff < probe) begin
            high_p1_in = mid;
         end else begin
            low_in = mid + BOUND_W'(1);
         end
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.capture) begin
         rsp_in.found       = hit;
         rsp_in.found_index = hit ? mid[IDX_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_entry && (int'(req_data.entry_index) < TABLE_DEPTH)) begin
         table_ff[ADDR_W'(req_data.entry_index)] <= req_data.entry_value;
      end
      if (cmd.start) begin
         key_ff <= req_data.search_key;
      end
      low_ff     <= low_in;
      high_p1_ff <= high_p1_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- rtl/sorted_table_binary_search_top.sv -----
// Operation: a load is written at its accept edge and gives no response. A search
// raises response valid after its probe loop: one midpoint probe per step (at most
// log2(depth)+1 probes), plus one more check on a miss to see the window empty.
// Throughput: one load per cycle while idle; no new request is accepted while a
// search probes or while a full output register holds the finished search.
// Reset (synchronous, active high) clears control and response valid, not the table.
`timescale 1ns / 1ps
`include "sorted_table_binary_search_top_assert.svh"
module sorted_table_binary_search_top (
   input logic       clock,
   input logic       reset,
   stbs_req_if.sink   req_chan,
   stbs_rsp_if.source rsp_chan
);
   import stbs_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_valid;
   logic          req_ready;
   logic          req_kind;
   logic          rsp_valid;
   logic          rsp_ready;
   logic          req_accept;

   assign req_valid      = req_chan.valid;
   assign req_kind       = req_chan.data.kind;
   assign req_chan.ready = req_ready;
   assign rsp_ready      = rsp_chan.ready;
   assign rsp_chan.valid = rsp_valid;
   assign req_accept     = req_valid & req_ready;

   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   stbs_dp u_dp (
      .clock    (clock),
      .req_data (req_chan.data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_chan.data)
   );

   // a search holds off new requests while it probes
   `STBS_ASSERT(a_search_blocks, (req_accept && req_kind == KIND_SEARCH) |=> !req_ready, "search accepted but request side still ready")
   // a response only appears from a finished search
   `STBS_ASSERT(a_rsp_from_capture, $rose(rsp_valid) |-> $past(cmd.capture), "response raised without a capture")
   // loads never produce a response
   `STBS_ASSERT(a_load_silent, (req_accept && req_kind == KIND_LOAD && !rsp_valid) |=> !rsp_valid, "load produced a response")
   // no response pending right after reset
   `STBS_ASSERT_RST(a_reset_clear, $past(reset) |-> !rsp_valid, "response valid after reset")

endmodule
